// ===== hdl/kcl_pkg.sv =====
package kcl_pkg;

   localparam int BUFFER_DEPTH = 7;
   localparam int POS_W        = $clog2(BUFFER_DEPTH);
   localparam int KEY_W        = 8;
   localparam int CODE_KEYS    = 3;
   localparam int SUFFIX_KEYS  = 5;
   localparam int SUFFIX_W     = SUFFIX_KEYS * KEY_W;
   localparam int DOOR_W       = CODE_KEYS * KEY_W;
   localparam int EVENT_W      = 3;
   localparam int CSR_IDX_W    = 8;

   // buffer positions that close a door code entry and a command entry
   localparam logic [POS_W-1:0] POS_CODE_DONE = POS_W'(CODE_KEYS);
   localparam logic [POS_W-1:0] POS_CMD_DONE  = POS_W'(2 + SUFFIX_KEYS - 1);
   localparam logic [POS_W-1:0] POS_LAST      = POS_W'(BUFFER_DEPTH - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_STAR   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_HASH   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ADD    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_CHANGE = CSR_IDX_W'(3);

   // register reset values
   localparam logic [KEY_W-1:0]    STAR_RESET   = 8'd10;
   localparam logic [KEY_W-1:0]    HASH_RESET   = 8'd11;
   localparam logic [SUFFIX_W-1:0] ADD_RESET    = 40'h0B_0403_0201;
   localparam logic [SUFFIX_W-1:0] CHANGE_RESET = 40'h0B_0000_0000;
   localparam logic [KEY_W-1:0]    KEY_SEVEN    = 8'd7;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE         = 3'd0,
      EV_CODE_OK      = 3'd1,
      EV_ADD_TOKEN    = 3'd2,
      EV_CHANGE_START = 3'd3,
      EV_CHANGE_DONE  = 3'd4,
      EV_CHANGE_ERROR = 3'd5
   } event_type;

   typedef struct packed {
      logic [KEY_W-1:0]    star_code;
      logic [KEY_W-1:0]    hash_code;
      logic [SUFFIX_W-1:0] add_token_suffix;
      logic [SUFFIX_W-1:0] change_code_suffix;
   } cfg_type;

endpackage

// ===== hdl/kcl_csr.sv =====
module kcl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kcl_pkg::SUFFIX_W-1:0]  csr_data,
   output kcl_pkg::cfg_type              cfg
);

   kcl_pkg::cfg_type cfg_ff;
   kcl_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kcl_pkg::CSR_IDX_STAR:   cfg_in.star_code = csr_data[kcl_pkg::KEY_W-1:0];
            kcl_pkg::CSR_IDX_HASH:   cfg_in.hash_code = csr_data[kcl_pkg::KEY_W-1:0];
            kcl_pkg::CSR_IDX_ADD:    cfg_in.add_token_suffix = csr_data;
            kcl_pkg::CSR_IDX_CHANGE: cfg_in.change_code_suffix = csr_data;
            default:                 cfg_in = cfg_ff;  // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.star_code          <= kcl_pkg::STAR_RESET;
         cfg_ff.hash_code          <= kcl_pkg::HASH_RESET;
         cfg_ff.add_token_suffix   <= kcl_pkg::ADD_RESET;
         cfg_ff.change_code_suffix <= kcl_pkg::CHANGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/kcl_core.sv =====
module kcl_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [kcl_pkg::KEY_W-1:0]   key,
   input  kcl_pkg::cfg_type            cfg,
   output kcl_pkg::event_type          event_res,
   output logic [kcl_pkg::DOOR_W-1:0]  door_code
);

   logic [kcl_pkg::KEY_W-1:0] buffer_ff [kcl_pkg::BUFFER_DEPTH];
   logic [kcl_pkg::KEY_W-1:0] buffer_in [kcl_pkg::BUFFER_DEPTH];
   logic [kcl_pkg::POS_W-1:0] position_ff;
   logic [kcl_pkg::POS_W-1:0] position_in;
   logic                      pending_ff;
   logic                      pending_in;
   logic [kcl_pkg::KEY_W-1:0] stored_ff [kcl_pkg::CODE_KEYS];
   logic [kcl_pkg::KEY_W-1:0] stored_in [kcl_pkg::CODE_KEYS];

   logic                         is_star;
   logic [kcl_pkg::SUFFIX_W-1:0] suffix_keys;
   logic                         add_match;
   logic                         change_match;
   logic                         new_code_bad;
   logic                         code_match;

   // buffer update
   always_comb begin
      is_star = (key == cfg.star_code);
      if (is_star) begin
         position_in = '0;
      end else if (position_ff == kcl_pkg::POS_LAST) begin
         position_in = '0;
      end else begin
         position_in = position_ff + kcl_pkg::POS_W'(1);
      end
      for (int i = 0; i < kcl_pkg::BUFFER_DEPTH; i++) begin
         if (position_in == kcl_pkg::POS_W'(i)) begin
            buffer_in[i] = key;
         end else if (is_star) begin
            buffer_in[i] = '0;
         end else begin
            buffer_in[i] = buffer_ff[i];
         end
      end
   end

   // sequence checks on the updated buffer
   always_comb begin
      suffix_keys  = {buffer_in[6], buffer_in[5], buffer_in[4], buffer_in[3], buffer_in[2]};
      add_match    = (suffix_keys == cfg.add_token_suffix);
      change_match = (suffix_keys == cfg.change_code_suffix);
      new_code_bad = 1'b0;
      code_match   = 1'b1;
      for (int i = 0; i < kcl_pkg::CODE_KEYS; i++) begin
         if (buffer_in[i+1] == cfg.star_code || buffer_in[i+1] == cfg.hash_code) begin
            new_code_bad = 1'b1;
         end
         if (stored_ff[i] != buffer_in[i+1]) begin
            code_match = 1'b0;
         end
      end
   end

   always_comb begin
      event_res  = kcl_pkg::EV_NONE;
      pending_in = pending_ff;
      stored_in  = stored_ff;
      if (buffer_in[0] != cfg.star_code) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            event_res  = kcl_pkg::EV_CHANGE_ERROR;
         end
      end else if (pending_ff) begin
         if (position_in >= kcl_pkg::POS_CODE_DONE) begin
            pending_in = 1'b0;
            if (new_code_bad) begin
               event_res = kcl_pkg::EV_CHANGE_ERROR;
            end else begin
               event_res = kcl_pkg::EV_CHANGE_DONE;
               for (int i = 0; i < kcl_pkg::CODE_KEYS; i++) begin
                  stored_in[i] = buffer_in[i+1];
               end
            end
         end
      end else if (buffer_in[1] == cfg.hash_code) begin
         if (position_in >= kcl_pkg::POS_CMD_DONE) begin
            if (add_match) begin
               event_res = kcl_pkg::EV_ADD_TOKEN;
            end else if (change_match) begin
               event_res  = kcl_pkg::EV_CHANGE_START;
               pending_in = 1'b1;
            end
         end
      end else if (position_in >= kcl_pkg::POS_CODE_DONE && code_match) begin
         event_res = kcl_pkg::EV_CODE_OK;
      end
   end

   assign door_code = {stored_in[2], stored_in[1], stored_in[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kcl_pkg::BUFFER_DEPTH; i++) begin
            buffer_ff[i] <= '0;
         end
         for (int i = 0; i < kcl_pkg::CODE_KEYS; i++) begin
            stored_ff[i] <= kcl_pkg::KEY_SEVEN;
         end
         position_ff <= '0;
         pending_ff  <= 1'b0;
      end else if (step) begin
         buffer_ff   <= buffer_in;
         stored_ff   <= stored_in;
         position_ff <= position_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

// ===== hdl/keypad_code_lock_sequencer.sv =====
// Keypad code lock sequencer.
// A key taken into the key register is judged on its way to the result register.
// Throughput: one key per cycle while the result channel is ready; the key and result
// registers each hold one beat, and the lock state updates in a single pass between them.
// Reset (synchronous, active high): buffer and position cleared, door code 7-7-7,
// no change pending, registers back to their defaults, both stages empty.
module keypad_code_lock_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   // key channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kcl_pkg::KEY_W-1:0]     req_key,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kcl_pkg::EVENT_W-1:0]   rsp_event_res,
   output logic [kcl_pkg::DOOR_W-1:0]    rsp_door_code,
   // register write port
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kcl_pkg::SUFFIX_W-1:0]  csr_data
);

   kcl_pkg::cfg_type cfg;

   // key stage
   logic                      key_valid_ff;
   logic [kcl_pkg::KEY_W-1:0] key_ff;

   // result stage
   logic                        rsp_valid_ff;
   logic [kcl_pkg::EVENT_W-1:0] rsp_event_ff;
   logic [kcl_pkg::DOOR_W-1:0]  rsp_door_ff;

   kcl_pkg::event_type          core_event;
   logic [kcl_pkg::DOOR_W-1:0]  core_door;
   logic                        advance;

   // key moves to the result stage when that stage is empty or drains now
   assign advance   = key_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !key_valid_ff || advance;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_door_code = rsp_door_ff;

   kcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // lock state commits only on advance, so each key is judged once
   kcl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .key       (key_ff),
      .cfg       (cfg),
      .event_res (core_event),
      .door_code (core_door)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            key_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ff <= req_key;
      end
      if (advance) begin
         rsp_event_ff <= core_event;
         rsp_door_ff  <= core_door;
      end
   end

endmodule

// ===== sim/keypad_code_lock_checker.sv =====
module keypad_code_lock_checker
   import kcl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [KEY_W-1:0]     req_key,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [EVENT_W-1:0]   rsp_event_res,
   input  logic [DOOR_W-1:0]    rsp_door_code,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SUFFIX_W-1:0]  csr_data,
   output int unsigned          beats_due,
   output int unsigned          fail_count
);

   typedef struct packed {
      event_type         ev;
      logic [DOOR_W-1:0] door;
   } lock_result_type;

   // lock state mirror
   logic [KEY_W-1:0]    key_buf [BUFFER_DEPTH];
   logic [POS_W-1:0]    key_pos;
   bit                  change_armed;
   logic [KEY_W-1:0]    door_keys [CODE_KEYS];
   logic [KEY_W-1:0]    star_key, hash_key;
   logic [SUFFIX_W-1:0] add_suffix, change_suffix;

   lock_result_type     lock_results_due [$];
   int unsigned         mismatches = 0;

   function automatic bit suffix_hit(input logic [SUFFIX_W-1:0] suffix);
      for (int i = 0; i < SUFFIX_KEYS; i++)
         if (key_buf[2 + i] != suffix[KEY_W*i +: KEY_W])
            return 1'b0;
      return 1'b1;
   endfunction

   // advances the mirror by one key and returns the result it should give
   function automatic lock_result_type press_key(input logic [KEY_W-1:0] k);
      lock_result_type res;
      bit              bad;
      res.ev = EV_NONE;
      if (k == star_key) begin
         foreach (key_buf[i])
            key_buf[i] = '0;
         key_pos    = '0;
         key_buf[0] = k;
      end else begin
         key_pos          = (key_pos == POS_LAST) ? '0 : key_pos + 1'b1;
         key_buf[key_pos] = k;
      end

      if (key_buf[0] != star_key) begin
         if (change_armed) begin
            change_armed = 1'b0;
            res.ev       = EV_CHANGE_ERROR;
         end
      end else if (change_armed) begin
         if (key_pos >= POS_CODE_DONE) begin
            bad = 1'b0;
            for (int i = 1; i <= CODE_KEYS; i++)
               if (key_buf[i] == star_key || key_buf[i] == hash_key)
                  bad = 1'b1;
            change_armed = 1'b0;
            if (bad)
               res.ev = EV_CHANGE_ERROR;
            else begin
               for (int i = 0; i < CODE_KEYS; i++)
                  door_keys[i] = key_buf[i + 1];
               res.ev = EV_CHANGE_DONE;
            end
         end
      end else if (key_buf[1] == hash_key) begin
         if (key_pos >= POS_CMD_DONE) begin
            if (suffix_hit(add_suffix))
               res.ev = EV_ADD_TOKEN;
            else if (suffix_hit(change_suffix)) begin
               change_armed = 1'b1;
               res.ev       = EV_CHANGE_START;
            end
         end
      end else if (key_pos >= POS_CODE_DONE && key_buf[1] == door_keys[0] &&
                   key_buf[2] == door_keys[1] && key_buf[3] == door_keys[2]) begin
         res.ev = EV_CODE_OK;
      end

      res.door = {door_keys[2], door_keys[1], door_keys[0]};
      return res;
   endfunction

   always @(posedge clock) begin
      lock_result_type due;
      if (reset) begin
         foreach (key_buf[i])
            key_buf[i] = '0;
         foreach (door_keys[i])
            door_keys[i] = KEY_SEVEN;
         key_pos       = '0;
         change_armed  = 1'b0;
         star_key      = STAR_RESET;
         hash_key      = HASH_RESET;
         add_suffix    = ADD_RESET;
         change_suffix = CHANGE_RESET;
         lock_results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDX_STAR:   star_key      = csr_data[KEY_W-1:0];
               CSR_IDX_HASH:   hash_key      = csr_data[KEY_W-1:0];
               CSR_IDX_ADD:    add_suffix    = csr_data;
               CSR_IDX_CHANGE: change_suffix = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (lock_results_due.size() == 0) begin
               $error("result beat with nothing expected: event_res %0d door_code %h",
                      rsp_event_res, rsp_door_code);
               mismatches++;
            end else begin
               due = lock_results_due.pop_front();
               if (rsp_event_res !== due.ev) begin
                  $error("event_res: expected %0d, actual %0d", due.ev, rsp_event_res);
                  mismatches++;
               end
               if (rsp_door_code !== due.door) begin
                  $error("door_code: expected %h, actual %h", due.door, rsp_door_code);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            lock_results_due.push_back(press_key(req_key));
      end
      beats_due  <= lock_results_due.size();
      fail_count <= mismatches;
   end

endmodule

// ===== sim/keypad_code_lock_sequencer_tb.sv =====
module keypad_code_lock_sequencer_tb;
   import kcl_pkg::*;

   // indexes past the register file, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_STRAY_LO = CSR_IDX_CHANGE + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_STRAY_HI = '1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid, req_ready;
   logic [KEY_W-1:0]     req_key;
   logic                 rsp_valid, rsp_ready;
   logic [EVENT_W-1:0]   rsp_event_res;
   logic [DOOR_W-1:0]    rsp_door_code;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SUFFIX_W-1:0]  csr_data;

   int unsigned          beats_due, fail_count;

   // stimulus-side view of the settings, used only to shape key sequences
   logic [KEY_W-1:0]     cur_star = STAR_RESET;
   logic [KEY_W-1:0]     cur_hash = HASH_RESET;
   logic [SUFFIX_W-1:0]  cur_add  = ADD_RESET;
   logic [SUFFIX_W-1:0]  cur_chg  = CHANGE_RESET;
   // best guess of the stored door code, so that code entries hit now and then
   logic [KEY_W-1:0]     door_guess [CODE_KEYS] = '{KEY_SEVEN, KEY_SEVEN, KEY_SEVEN};

   int unsigned          keys_sent = 0;
   bit                   calm      = 1'b0;  // sender: no gaps in this sequence
   logic                 quiet     = 1'b0;  // tail of the run: nobody idles
   int unsigned          stall_left = 0, open_left = 0;

   always #2 clock = ~clock;

   keypad_code_lock_sequencer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_door_code (rsp_door_code),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   keypad_code_lock_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_door_code (rsp_door_code),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .beats_due     (beats_due),
      .fail_count    (fail_count)
   );

   // Result side backpressure: stall bursts and open stretches of random length;
   // always open once the tail starts.
   always @(posedge clock) begin
      if (reset || quiet)
         rsp_ready <= 1'b1;
      else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (open_left != 0) begin
         open_left--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 1) != 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         open_left = $urandom_range(0, 29);
         rsp_ready <= 1'b1;
      end
   end

   // any key that is neither star nor hash under the given settings
   function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] star,
                                                 input logic [KEY_W-1:0] hash);
      logic [KEY_W-1:0] k;
      do
         k = KEY_W'($urandom_range(0, 255));
      while (k == star || k == hash);
      return k;
   endfunction

   function automatic logic [SUFFIX_W-1:0] rand_suffix(input logic [KEY_W-1:0] star,
                                                       input logic [KEY_W-1:0] hash);
      logic [SUFFIX_W-1:0] s;
      for (int i = 0; i < SUFFIX_KEYS; i++)
         s[KEY_W*i +: KEY_W] = pick_key(star, hash);
      return s;
   endfunction

   // One key beat. Valid stays up after the handshake; the next beat or an
   // idle burst decides what happens to it, never both in one step.
   task automatic send_key(input logic [KEY_W-1:0] k);
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= k;
      do @(posedge clock); while (!req_ready);
      keys_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [SUFFIX_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain the lock, then rewrite all four registers. Upper data bits of the
   // key registers carry junk that must be ignored.
   task automatic load_settings(input logic [KEY_W-1:0] star, input logic [KEY_W-1:0] hash,
                                input logic [SUFFIX_W-1:0] add,
                                input logic [SUFFIX_W-1:0] chg, input bit stray);
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_due != 0);
      repeat (4) @(posedge clock);
      if (stray)
         write_csr(CSR_IDX_STRAY_LO, ~add);
      write_csr(CSR_IDX_STAR, {32'($urandom), star});
      write_csr(CSR_IDX_HASH, {32'($urandom), hash});
      write_csr(CSR_IDX_ADD, add);
      write_csr(CSR_IDX_CHANGE, chg);
      if (stray)
         write_csr(CSR_IDX_STRAY_HI, '1);
      csr_valid <= 1'b0;
      cur_star = star;
      cur_hash = hash;
      cur_add  = add;
      cur_chg  = chg;
   endtask

   task automatic send_suffix(input logic [SUFFIX_W-1:0] s);
      for (int i = 0; i < SUFFIX_KEYS; i++)
         send_key(s[KEY_W*i +: KEY_W]);
   endtask

   // One random key sequence, mostly well formed with random content.
   task automatic play_sequence();
      int unsigned       pick, bad, n;
      logic [KEY_W-1:0]  nk [CODE_KEYS];
      logic [SUFFIX_W-1:0] s;
      pick = $urandom_range(0, 99);
      calm = ($urandom_range(0, 3) == 0);
      if (pick < 25) begin
         // door code attempt, right or wrong
         send_key(cur_star);
         for (int i = 0; i < CODE_KEYS; i++)
            send_key(($urandom_range(0, 1) != 0) ? door_guess[i] : pick_key(cur_star, cur_hash));
      end else if (pick < 45) begin
         // add-token command, sometimes with one wrong key
         s = cur_add;
         if ($urandom_range(0, 4) == 0)
            s[KEY_W*$urandom_range(0, SUFFIX_KEYS-1) +: KEY_W] = KEY_W'($urandom_range(0, 255));
         send_key(cur_star);
         send_key(cur_hash);
         send_suffix(s);
      end else if (pick < 68) begin
         // change-code command followed by the new code
         send_key(cur_star);
         send_key(cur_hash);
         send_suffix(cur_chg);
         case ($urandom_range(0, 7))
            0: send_key(pick_key(cur_star, cur_hash));        // no leading star: cancel
            1: begin                                          // short entry, still pending
               send_key(cur_star);
               send_key(pick_key(cur_star, cur_hash));
            end
            default: ;
         endcase
         bad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, CODE_KEYS) : 0;
         foreach (nk[i])
            nk[i] = pick_key(cur_star, cur_hash);
         if (bad != 0)
            nk[bad-1] = cur_hash;
         send_key(cur_star);
         foreach (nk[i])
            send_key(nk[i]);
         if (bad == 0)
            door_guess = nk;
      end else if (pick < 85) begin
         // noise over the full key range, star and hash included now and then
         n = $urandom_range(1, 8);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0:       send_key(cur_star);
               1:       send_key(cur_hash);
               default: send_key(KEY_W'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         // long entry that wraps the buffer position
         send_key(cur_star);
         n = $urandom_range(BUFFER_DEPTH, 2*BUFFER_DEPTH);
         repeat (n)
            send_key(pick_key(cur_star, cur_hash));
      end
   endtask

   task automatic run_random(input int unsigned n);
      int unsigned stop_at;
      stop_at = keys_sent + n;
      while (keys_sent < stop_at)
         play_sequence();
   endtask

   initial begin
      logic [SUFFIX_W-1:0] s;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_key   <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, default settings: change command, short entry, new code 255-0-128
      // with both key extremes, the new code accepted, then a change cancelled
      // by a key with no leading star
      calm = 1'b1;
      send_key(STAR_RESET);
      send_key(HASH_RESET);
      send_suffix(CHANGE_RESET);
      send_key(STAR_RESET);
      send_key(8'd0);
      send_key(STAR_RESET);
      send_key(8'd255);
      send_key(8'd0);
      send_key(8'd128);
      send_key(STAR_RESET);
      send_key(8'd255);
      send_key(8'd0);
      send_key(8'd128);
      send_key(STAR_RESET);
      send_key(HASH_RESET);
      send_suffix(CHANGE_RESET);
      send_key(8'd42);
      door_guess = '{8'd255, 8'd0, 8'd128};

      // random phases, one per setting, the last setting followed by a quiet tail
      run_random(310);
      load_settings(8'h00, 8'hFF, rand_suffix(8'h00, 8'hFF), rand_suffix(8'h00, 8'hFF), 1'b1);
      run_random(310);
      // all-ones add suffix holds the star key, so only change commands get through
      load_settings(8'hFF, 8'h00, '1, '0, 1'b0);
      run_random(310);
      // star and hash equal: command sequences cannot form
      load_settings(8'h5A, 8'h5A, rand_suffix(8'h5A, 8'h5A), rand_suffix(8'h5A, 8'h5A), 1'b0);
      run_random(250);
      // both suffixes equal: add-token must win
      s = rand_suffix(8'h80, 8'h01);
      load_settings(8'h80, 8'h01, s, s, 1'b0);
      run_random(310);
      load_settings(STAR_RESET, HASH_RESET, ADD_RESET, CHANGE_RESET, 1'b1);
      run_random(200);
      quiet <= 1'b1;
      run_random(200);

      req_valid <= 1'b0;
      do @(posedge clock); while (beats_due != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[keypad_code_lock_sequencer] OK");
      else
         $display("[keypad_code_lock_sequencer] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("[keypad_code_lock_sequencer] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/kcl_pkg.sv
hdl/kcl_csr.sv
hdl/kcl_core.sv
hdl/keypad_code_lock_sequencer.sv
sim/keypad_code_lock_checker.sv
sim/keypad_code_lock_sequencer_tb.sv
